/* sv/hall_six_step_commutator_unit_macros.svh */
// Assertion macros shared by the hall six-step commutator RTL.
`ifndef HALL_SIX_STEP_COMMUTATOR_UNIT_MACROS_SVH
`define HALL_SIX_STEP_COMMUTATOR_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define HSSC_ASSERT_NOW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold at the clock edge after the antecedent.
`define HSSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hssc_pkg.sv */
// Types, codes and constants of the hall six-step commutator.
package hssc_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_HALL_MAP      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DIRECTION     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DUTY          = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_FEEDBACK_MODE = 3'd3;

   // request kinds
   localparam logic [1:0] REQ_HALL  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   // feedback modes
   localparam logic FB_HALL = 1'b0;

   localparam logic [3:0]  MAX_STEP      = 4'd5;
   localparam logic [31:0] HALL_MAP_INIT = 32'hFFFF_FFFF;
   localparam logic [15:0] ERR_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  hall_code;
      logic        hall_missing;
      logic        hard_fault;
      logic [31:0] time_ms;
   } hssc_req_type;

   typedef struct packed {
      logic               drive_valid;
      logic [2:0]         drive_step;
      logic [15:0]        drive_duty;
      logic               phases_float;
      logic               running;
      logic               sensor_connected;
      logic               start_failed;
      logic [15:0]        sequence_errors;
      logic signed [31:0] position_steps;
      logic signed [31:0] interval_steps;
      logic [31:0]        interval_ms;
   } hssc_rsp_type;

   typedef struct packed {
      logic [31:0] hall_map;
      logic        direction;
      logic [15:0] duty;
      logic        feedback_mode;
   } hssc_cfg_type;

   typedef struct packed {
      logic [2:0]  prev_step;
      logic [31:0] step_total;
      logic [31:0] step_total_at_tick;
      logic [31:0] tick_time_last;
      logic [15:0] error_total;
      logic        run_flag;
      logic        connected_flag;
      logic        fail_flag;
   } hssc_state_type;

endpackage

/* sv/hall_six_step_commutator_unit.sv */
// Top level of the hall six-step commutator: request/response channels and CSRs.
//
// Usage:
//   req channel carries one event (hall change, start, stop, tick) per request.
//   rsp channel returns exactly one result per request, in order.
//   csr channel writes hall_map, direction, duty and feedback_mode; csr_ready
//   is always high. Write CSRs only while no request is in flight.
// Timing:
//   A request lands in an input register, its state update and result are
//   computed in one pass and the result is registered in the output register,
//   which raises rsp_valid. One request per cycle is sustained while rsp_ready
//   is high.
// Stall:
//   When rsp_ready is low the result holds in the output register and one more
//   request is still taken into the input register; then req_ready drops.
// Reset:
//   Synchronous, active high. Clears both pipeline valids, sets CSRs to their
//   defaults (hall_map all invalid) and the tracker state to zero with the
//   sensor marked connected.
`include "hall_six_step_commutator_unit_macros.svh"

module hall_six_step_commutator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hssc_pkg::hssc_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hssc_pkg::hssc_rsp_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hssc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [hssc_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import hssc_pkg::*;

   logic           in_valid_ff;
   hssc_req_type   in_item_ff;
   logic           out_valid_ff;
   hssc_rsp_type   out_rsp_ff;
   hssc_cfg_type   cfg_ff;
   hssc_state_type state_ff;
   hssc_state_type state_in;
   hssc_rsp_type   rsp_in;
   logic           advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   hssc_update u_update (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.prev_step          <= 3'd0;
         state_ff.step_total         <= '0;
         state_ff.step_total_at_tick <= '0;
         state_ff.tick_time_last     <= '0;
         state_ff.error_total        <= '0;
         state_ff.run_flag           <= 1'b0;
         state_ff.connected_flag     <= 1'b1;
         state_ff.fail_flag          <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hall_map      <= HALL_MAP_INIT;
         cfg_ff.direction     <= 1'b0;
         cfg_ff.duty          <= '0;
         cfg_ff.feedback_mode <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HALL_MAP:      cfg_ff.hall_map      <= csr_wdata;
            CSR_DIRECTION:     cfg_ff.direction     <= csr_wdata[0];
            CSR_DUTY:          cfg_ff.duty          <= csr_wdata[15:0];
            CSR_FEEDBACK_MODE: cfg_ff.feedback_mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   `HSSC_ASSERT_NOW(a_drive_needs_run, clock, reset,
      (!out_valid_ff || !out_rsp_ff.drive_valid || out_rsp_ff.running),
      "drive commanded while not running")
   `HSSC_ASSERT_NOW(a_float_stops, clock, reset,
      (!out_valid_ff || !out_rsp_ff.phases_float
       || (!out_rsp_ff.running && !out_rsp_ff.drive_valid)),
      "phases floated but still running or driving")
   `HSSC_ASSERT_NOW(a_idle_drive_zero, clock, reset,
      (!out_valid_ff || out_rsp_ff.drive_valid
       || (out_rsp_ff.drive_step == 3'd0 && out_rsp_ff.drive_duty == 16'd0)),
      "drive fields nonzero without a drive command")
   `HSSC_ASSERT_NEXT(a_disconnect_sticky, clock, reset,
      (!state_ff.connected_flag), (!state_ff.connected_flag),
      "sensor connected flag set again after loss")

endmodule

/* sv/hssc_update.sv */
// Next-state and result logic for one commutator request.
module hssc_update (
   input  hssc_pkg::hssc_cfg_type   cfg,
   input  hssc_pkg::hssc_state_type state,
   input  hssc_pkg::hssc_req_type   item,
   output hssc_pkg::hssc_state_type state_next,
   output hssc_pkg::hssc_rsp_type   rsp
);
   import hssc_pkg::*;

   logic              start_ok;
   logic              do_hall;
   logic              conn_mid;
   logic [3:0]        step;
   logic signed [3:0] diff;
   logic signed [3:0] delta;

   assign step = cfg.hall_map[{item.hall_code, 2'b00} +: 4];

   always_comb begin
      diff = $signed({1'b0, step[2:0]}) - $signed({1'b0, state.prev_step});
      if (diff > 4'sd2) begin
         delta = diff - 4'sd6;
      end else if (diff < -4'sd3) begin
         delta = diff + 4'sd6;
      end else begin
         delta = diff;
      end
   end

   always_comb begin
      state_next = state;
      rsp        = '0;

      conn_mid = state.connected_flag;
      if (item.req_type == REQ_START && item.hall_missing) begin
         conn_mid             = 1'b0;
         state_next.fail_flag = 1'b1;
      end
      state_next.connected_flag = conn_mid;

      start_ok = !item.hard_fault && !state.run_flag && cfg.feedback_mode == FB_HALL
                 && conn_mid;
      do_hall  = item.req_type == REQ_HALL || (item.req_type == REQ_START && start_ok);

      unique case (item.req_type)
         REQ_START: begin
            if (start_ok) begin
               state_next.run_flag = 1'b1;
            end
         end
         REQ_STOP: begin
            rsp.phases_float    = 1'b1;
            state_next.run_flag = 1'b0;
         end
         REQ_TICK: begin
            rsp.interval_steps            = $signed(state.step_total - state.step_total_at_tick);
            rsp.interval_ms               = item.time_ms - state.tick_time_last;
            state_next.tick_time_last     = item.time_ms;
            state_next.step_total_at_tick = state.step_total;
         end
         default: begin
         end
      endcase

      // drop a repeated step; an invalid one marks the sensor lost and counts an error
      if (do_hall && step != {1'b0, state.prev_step}) begin
         if (step > MAX_STEP) begin
            state_next.connected_flag = 1'b0;
            if (state.error_total != ERR_MAX) begin
               state_next.error_total = state.error_total + 16'd1;
            end
         end else begin
            if (delta > 4'sd1 || delta < -4'sd1) begin
               if (state.error_total != ERR_MAX) begin
                  state_next.error_total = state.error_total + 16'd1;
               end
            end
            state_next.step_total = state.step_total + {{28{delta[3]}}, delta};
            state_next.prev_step  = step[2:0];
            // start sees run_flag low, so it never drives
            if (state.run_flag && cfg.feedback_mode == FB_HALL) begin
               rsp.drive_valid = 1'b1;
               rsp.drive_step  = cfg.direction ? (MAX_STEP[2:0] - step[2:0]) : step[2:0];
               rsp.drive_duty  = cfg.duty;
            end
         end
      end

      rsp.running          = state_next.run_flag;
      rsp.sensor_connected = state_next.connected_flag;
      rsp.start_failed     = state_next.fail_flag;
      rsp.sequence_errors  = state_next.error_total;
      rsp.position_steps   = $signed(state_next.step_total);
   end

endmodule
